// ----- rtl/bqlp_pkg.sv -----
package bqlp_pkg;

    localparam int SAMPLE_W = 15;
    localparam int OUT_W    = 17;
    localparam int B0_W     = 25;
    localparam int B1_W     = 26;
    localparam int A1_W     = 27;
    localparam int A2_W     = 26;
    localparam int BIAS_W   = 15;
    localparam int HIST_W   = 32;
    localparam int ACC_W    = 64;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [OUT_W-1:0]    filt_t;
    typedef logic        [APB_AW-1:0]   apb_addr_t;
    typedef logic        [APB_DW-1:0]   apb_data_t;

    // register word index (byte address / 4)
    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_B0   = 3'd0;
    localparam reg_idx_t REG_B1   = 3'd1;
    localparam reg_idx_t REG_A1   = 3'd2;
    localparam reg_idx_t REG_A2   = 3'd3;
    localparam reg_idx_t REG_BIAS = 3'd4;

endpackage

// ----- rtl/biquad_lowpass_fixed_point.sv -----
// Channel   Handshake                 Payload
// -------   -----------------------   -----------------------------
// in        in_valid / in_stall       sample   (15 bit signed)
// out       out_valid / out_stall     filtered (17 bit signed)
// cfg       APB write/read, pready=1  coefficients and offset at 4*i
//
// One word per cycle sustained while out_stall is low. A filtered word is
// registered into the output slot when its sample advances from the input
// register. The feedback path (four multipliers, the accumulator sum and the
// shift back into y history) is combinational, which sets the rate.
// Reset clears valids, coefficients, history and the primed flag; no sweep.
// A stalled output holds its word and backs pressure up through in_stall.
// Writes to defined registers clear primed; the next sample refills all history.
module biquad_lowpass_fixed_point #(
    parameter int COEF_FRAC_BITS  = 24,
    parameter int INPUT_FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // input word
    input  logic                 in_valid,
    output logic                 in_stall,
    input  bqlp_pkg::sample_t    sample,
    // output word
    output logic                 out_valid,
    input  logic                 out_stall,
    output bqlp_pkg::filt_t      filtered,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  bqlp_pkg::apb_addr_t  paddr,
    input  bqlp_pkg::apb_data_t  pwdata,
    output bqlp_pkg::apb_data_t  prdata,
    output logic                 pready
);

    import bqlp_pkg::*;

    // accumulator after the coefficient shift, plus one guard bit for rounding
    localparam int SH_W  = ACC_W - COEF_FRAC_BITS;
    localparam int RS_W  = SH_W + 1 - INPUT_FRAC_BITS;
    localparam int RES_W = RS_W + 1;
    localparam logic signed [SH_W:0]    HALF    = (SH_W+1)'(1) <<< (INPUT_FRAC_BITS - 1);
    localparam logic signed [RES_W-1:0] OUT_MAX = RES_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [RES_W-1:0] OUT_MIN = -RES_W'(1 << (OUT_W - 1));

    // full product widths of the four multipliers
    localparam int PB0_W = HIST_W + B0_W + 2;
    localparam int PB1_W = HIST_W + B1_W + 1;
    localparam int PA1_W = HIST_W + A1_W;
    localparam int PA2_W = HIST_W + A2_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic        [B0_W-1:0]   coef_b0_reg;
    logic        [B1_W-1:0]   coef_b1_reg;
    logic signed [A1_W-1:0]   coef_a1_reg;
    logic signed [A2_W-1:0]   coef_a2_reg;
    logic signed [BIAS_W-1:0] offset_reg;

    logic     cfg_wr_en;
    logic     cfg_hit;
    reg_idx_t cfg_idx;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[4:2];
    assign cfg_wr_en = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (cfg_idx)
            REG_B0, REG_B1, REG_A1, REG_A2, REG_BIAS: cfg_hit = 1'b1;
            default:                                  cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_b0_reg <= '0;
            coef_b1_reg <= '0;
            coef_a1_reg <= '0;
            coef_a2_reg <= '0;
            offset_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx)
                REG_B0:   coef_b0_reg <= pwdata[B0_W-1:0];
                REG_B1:   coef_b1_reg <= pwdata[B1_W-1:0];
                REG_A1:   coef_a1_reg <= pwdata[A1_W-1:0];
                REG_A2:   coef_a2_reg <= pwdata[A2_W-1:0];
                REG_BIAS: offset_reg  <= pwdata[BIAS_W-1:0];
                default:  ;
            endcase
        end
    end

    // read back, signed registers sign-extended
    always_comb
    begin
        unique case (cfg_idx)
            REG_B0:   prdata = APB_DW'(coef_b0_reg);
            REG_B1:   prdata = APB_DW'(coef_b1_reg);
            REG_A1:   prdata = APB_DW'(coef_a1_reg);
            REG_A2:   prdata = APB_DW'(coef_a2_reg);
            REG_BIAS: prdata = APB_DW'(offset_reg);
            default:  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // handshake: input register feeds the output register
    // ------------------------------------------------------------------
    logic    in_valid_reg, in_valid_next;
    sample_t sample_reg;
    logic    out_valid_reg, out_valid_next;
    filt_t   filtered_reg, filtered_next;
    logic    in_accept;
    logic    advance;

    // advance when the input stage holds a word and the output slot frees up
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next  = in_accept || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            sample_reg <= sample;
        if (advance)
            filtered_reg <= filtered_next;
    end

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;

    // ------------------------------------------------------------------
    // filter datapath
    // ------------------------------------------------------------------
    logic signed [HIST_W-1:0] x_hist1_reg, x_hist1_next;
    logic signed [HIST_W-1:0] x_hist2_reg, x_hist2_next;
    logic signed [HIST_W-1:0] y_hist1_reg, y_hist1_next;
    logic signed [HIST_W-1:0] y_hist2_reg, y_hist2_next;
    logic                     primed_reg, primed_next;

    logic signed [SAMPLE_W:0]           diff;
    logic signed [HIST_W-1:0]           x0;
    logic signed [HIST_W-1:0]           x1, x2, y1, y2;
    logic signed [HIST_W:0]             x02;
    logic signed [PB0_W-1:0]            prod_b0;
    logic signed [PB1_W-1:0]            prod_b1;
    logic signed [PA1_W-1:0]            prod_a1;
    logic signed [PA2_W-1:0]            prod_a2;
    logic signed [ACC_W-1:0]            acc;
    logic signed [SH_W-1:0]             sh;
    logic signed [SH_W:0]               rnd;
    logic signed [RS_W-1:0]             rnd_sh;
    logic signed [RES_W-1:0]            res;

    always_comb
    begin
        // remove bias, scale up, wrap to history width
        diff = (SAMPLE_W+1)'(sample_reg) - (SAMPLE_W+1)'(offset_reg);
        x0   = HIST_W'(diff) <<< INPUT_FRAC_BITS;

        // first word after reset or a register write fills every tap
        x1 = primed_reg ? x_hist1_reg : x0;
        x2 = primed_reg ? x_hist2_reg : x0;
        y1 = primed_reg ? y_hist1_reg : x0;
        y2 = primed_reg ? y_hist2_reg : x0;

        // b0 is shared by the current and second-previous input
        x02     = (HIST_W+1)'(x0) + (HIST_W+1)'(x2);
        prod_b0 = PB0_W'(x02) * PB0_W'($signed({1'b0, coef_b0_reg}));
        prod_b1 = PB1_W'(x1) * PB1_W'($signed({1'b0, coef_b1_reg}));
        prod_a1 = PA1_W'(y1) * PA1_W'(coef_a1_reg);
        prod_a2 = PA2_W'(y2) * PA2_W'(coef_a2_reg);

        acc = ACC_W'(prod_b0) + ACC_W'(prod_b1) - ACC_W'(prod_a1) - ACC_W'(prod_a2);
        sh  = acc[ACC_W-1:COEF_FRAC_BITS];

        // round half up, restore bias, clamp
        rnd    = (SH_W+1)'(sh) + HALF;
        rnd_sh = rnd[SH_W:INPUT_FRAC_BITS];
        res    = RES_W'(rnd_sh) + RES_W'(offset_reg);

        if (res < OUT_MIN)
            filtered_next = OUT_MIN[OUT_W-1:0];
        else if (res > OUT_MAX)
            filtered_next = OUT_MAX[OUT_W-1:0];
        else
            filtered_next = res[OUT_W-1:0];

        // shift history on each word
        x_hist1_next = advance ? x0 : x_hist1_reg;
        x_hist2_next = advance ? x1 : x_hist2_reg;
        y_hist1_next = advance ? sh[HIST_W-1:0] : y_hist1_reg;
        y_hist2_next = advance ? y1 : y_hist2_reg;

        if (cfg_wr_en && cfg_hit)
            primed_next = 1'b0;
        else if (advance)
            primed_next = 1'b1;
        else
            primed_next = primed_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_hist1_reg <= '0;
            x_hist2_reg <= '0;
            y_hist1_reg <= '0;
            y_hist2_reg <= '0;
            primed_reg  <= 1'b0;
        end
        else
        begin
            x_hist1_reg <= x_hist1_next;
            x_hist2_reg <= x_hist2_next;
            y_hist1_reg <= y_hist1_next;
            y_hist2_reg <= y_hist2_next;
            primed_reg  <= primed_next;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("word advanced but output not valid");

    a_cfg_unprimes: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en && cfg_hit |=> !primed_reg)
        else $error("register write did not clear primed");

    a_prime_fills_taps: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !primed_reg |=> x_hist1_reg == x_hist2_reg)
        else $error("priming word did not fill input history");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without downstream backpressure");

endmodule
